### hw/rtl/kbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed block transposition block.
// Used by every module under hw/rtl; depends on nothing.
package kbt_pkg;

  localparam int MAX_BLOCK_DEF = 8;

  localparam logic [3:0]  LEN_RESET = 4'd8;
  localparam logic [23:0] KEY_RESET = 24'hFAC688;
  localparam logic [7:0]  PAD_FIRST = 8'h7A;

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_KEY_MAP      = 2'd1,
    REG_DECRYPT_MODE = 2'd2
  } reg_index_t;

  // One block of work handed from the front to the back.
  typedef struct packed {
    logic       bank;      // store bank holding the data bytes
    logic [3:0] count;     // data bytes present; positions above are padding
    logic [3:0] len;       // block length in force at completion
    logic       last;      // message ends with this job
    logic       pad_next;  // a whole padding block follows the data block
    logic       dec;       // decrypt permutation
  } job_t;

  // Back tells the front that a bank has been read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

### hw/rtl/kbt_front.sv
`timescale 1ns / 1ps
// Input side: collects bytes into two store banks and issues block jobs.
// Depends on kbt_pkg.
module kbt_front #(
  parameter int MAX_BLOCK = kbt_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  output logic                          full,
  input  logic [3:0]                    block_length,
  input  logic                          decrypt_mode,
  output logic                          job_valid,
  output kbt_pkg::job_t                 job,
  input  kbt_pkg::release_t             rel,
  input  logic                          rd_bank,
  input  logic [$clog2((MAX_BLOCK < 8) ? MAX_BLOCK : 8)-1:0] rd_idx,
  output logic [7:0]                    rd_data
);

  localparam int CAP = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
  localparam int IW  = $clog2(CAP);
  localparam logic [3:0] CAP_LEN = 4'(CAP);

  logic [7:0] store [2][CAP];
  logic [2:0] fill;
  logic       wr_bank;
  logic [1:0] busy;
  logic [1:0] busy_next;

  logic [3:0] len_eff;
  logic [3:0] count;
  logic       complete;
  logic       accept;

  always_comb begin
    if (block_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (block_length > CAP_LEN) begin
      len_eff = CAP_LEN;
    end else begin
      len_eff = block_length;
    end
  end

  assign full     = busy[wr_bank];
  assign accept   = push && !full;
  assign count    = {1'b0, fill} + 4'd1;
  assign complete = (count >= len_eff);

  // A decrypt tail that never fills a block issues nothing.
  assign job_valid    = accept && (complete || (in_last && !decrypt_mode));
  assign job.bank     = wr_bank;
  assign job.count    = complete ? len_eff : count;
  assign job.len      = len_eff;
  assign job.last     = in_last;
  assign job.pad_next = complete && in_last && !decrypt_mode;
  assign job.dec      = decrypt_mode;

  assign rd_data = store[rd_bank][rd_idx];

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (job_valid) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 3'd0;
      wr_bank <= 1'b0;
      busy    <= 2'b00;
    end else begin
      busy <= busy_next;
      if (job_valid) begin
        wr_bank <= !wr_bank;
      end
      if (accept) begin
        if (complete || in_last) begin
          fill <= 3'd0;
        end else begin
          fill <= count[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store[wr_bank][fill[IW-1:0]] <= in_byte;
    end
  end

`ifndef ASSERT_OFF
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    job_valid |=> wr_bank != $past(wr_bank))
    else $error("bank not swapped after job issue");

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that is not busy");
`endif

endmodule

### hw/rtl/kbt_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front and the back.
// Depends on kbt_pkg.
module kbt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kbt_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output kbt_pkg::job_t pop_data,
  output logic          empty
);

  kbt_pkg::job_t entry [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    used;

  assign full     = (used == 2'd2);
  assign empty    = (used == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        used <= used + 2'd1;
      end else if (pop && !push) begin
        used <= used - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("job queue underflow");
`endif

endmodule

### hw/rtl/kbt_back.sv
`timescale 1ns / 1ps
// Output side: reads a bank through the key map, one byte per cycle while the
// output is not stalled, and inserts padding. Depends on kbt_pkg.
module kbt_back #(
  parameter int MAX_BLOCK = kbt_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  kbt_pkg::job_t                 q_data,
  output logic                          q_pop,
  input  logic [23:0]                   key_map,
  output logic                          rd_bank,
  output logic [$clog2((MAX_BLOCK < 8) ? MAX_BLOCK : 8)-1:0] rd_idx,
  input  logic [7:0]                    rd_data,
  output kbt_pkg::release_t             rel,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);

  localparam int CAP = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
  localparam int IW  = $clog2(CAP);

  typedef enum logic {IDLE, RUN} state_t;

  state_t        state;
  kbt_pkg::job_t job;
  logic [2:0]    pos;
  logic          pad_phase;
  logic          out_valid;

  logic [2:0] key_e [8];
  logic [2:0] src_i;
  logic       hit;
  logic [3:0] cnt_eff;
  logic       use_store;
  logic [7:0] pad_byte;
  logic [7:0] value;
  logic       at_end;
  logic       final_phase;
  logic       advance;
  logic       job_done;

  always_comb begin
    for (int y = 0; y < 8; y++) begin
      key_e[y] = key_map[3*y +: 3];
    end
  end

  // Source position for this output position: direct key lookup on decrypt,
  // last matching key entry on encrypt.
  always_comb begin
    src_i = 3'd0;
    hit   = 1'b0;
    if (job.dec) begin
      src_i = key_e[pos];
      hit   = ({1'b0, key_e[pos]} < job.len);
    end else begin
      for (int y = 0; y < 8; y++) begin
        if ((4'(y) < job.len) && (key_e[y] == pos)) begin
          src_i = 3'(y);
          hit   = 1'b1;
        end
      end
    end
  end

  assign cnt_eff   = pad_phase ? 4'd0 : job.count;
  assign use_store = ({1'b0, src_i} < cnt_eff);
  assign pad_byte  = kbt_pkg::PAD_FIRST - ({5'd0, src_i} - {4'd0, cnt_eff});
  assign value     = hit ? (use_store ? rd_data : pad_byte) : 8'd0;

  assign rd_bank = job.bank;
  assign rd_idx  = src_i[IW-1:0];

  assign at_end      = ({1'b0, pos} == (job.len - 4'd1));
  assign final_phase = pad_phase || !job.pad_next;
  assign advance     = (state == RUN) && (!out_valid || pop);
  assign job_done    = advance && at_end && final_phase;
  assign q_pop       = !q_empty && ((state == IDLE) || job_done);

  assign rel.valid = job_done;
  assign rel.bank  = job.bank;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pos       <= 3'd0;
      pad_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        out_byte  <= value;
        out_last  <= job.last && final_phase && at_end;
        if (at_end) begin
          pos <= 3'd0;
          if (final_phase) begin
            pad_phase <= 1'b0;
            state     <= IDLE;
          end else begin
            pad_phase <= 1'b1;
          end
        end else begin
          pos <= pos + 3'd1;
        end
      end
      // Load the next job; overrides the drop to idle above.
      if (q_pop) begin
        job       <= q_data;
        state     <= RUN;
        pos       <= 3'd0;
        pad_phase <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> ({1'b0, pos} < job.len))
    else $error("read-out position beyond block length");
`endif

endmodule

### hw/rtl/keyed_block_transposition.sv
`timescale 1ns / 1ps
// Keyed block transposition: full blocks are permuted through the key map; on encrypt,
// the message end is padded: a short tail is filled out, else a padding block follows.
// Throughput: at most one byte per cycle while not full; a bank refills only after its
// read-out, and an idle back loads a queued job before its read-out starts.
// Reset: synchronous; clears counters, queue and output, restores register defaults.
module keyed_block_transposition #(
  parameter int MAX_BLOCK = kbt_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CAP = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
  localparam int IW  = $clog2(CAP);

  logic [3:0]  block_length;
  logic [23:0] key_map;
  logic        decrypt_mode;

  logic              job_valid;
  kbt_pkg::job_t     job_in;
  kbt_pkg::job_t     job_out;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  kbt_pkg::release_t rel;
  logic              rd_bank;
  logic [IW-1:0]     rd_idx;
  logic [7:0]        rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= kbt_pkg::LEN_RESET;
      key_map      <= kbt_pkg::KEY_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (kbt_pkg::reg_index_t'(cfg_index))
        kbt_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data[3:0];
        kbt_pkg::REG_KEY_MAP:      key_map      <= cfg_data;
        kbt_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kbt_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .full         (full),
    .block_length (block_length),
    .decrypt_mode (decrypt_mode),
    .job_valid    (job_valid),
    .job          (job_in),
    .rel          (rel),
    .rd_bank      (rd_bank),
    .rd_idx       (rd_idx),
    .rd_data      (rd_data)
  );

  kbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (job_out),
    .empty     (q_empty)
  );

  kbt_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (job_out),
    .q_pop    (q_pop),
    .key_map  (key_map),
    .rd_bank  (rd_bank),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .rel      (rel),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

`ifndef ASSERT_OFF
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !q_full)
    else $error("job issued with no queue room");
`endif

endmodule
